// ===== rtl/wbps_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the wildcard byte pattern scanner
// no dependencies; imported by every module of the block
package wbps_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int OFFSET_BITS = 32;
  localparam int OUT_OFF_W   = 32;
  localparam int LEN_W       = $clog2(PATTERN_MAX);
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = Q_PTR_W + 1;

  localparam logic [OFFSET_BITS-1:0] OFFSET_TOP = {OFFSET_BITS{1'b1}};

  // configuration register indexes
  localparam logic [1:0] REG_PAT_LO   = 2'd0;
  localparam logic [1:0] REG_PAT_HI   = 2'd1;
  localparam logic [1:0] REG_CARE     = 2'd2;
  localparam logic [1:0] REG_PAT_LEN  = 2'd3;

  typedef logic [PATTERN_MAX-1:0][7:0] byte_vec_t;

  typedef struct packed {
    byte_vec_t              pattern;
    logic [PATTERN_MAX-1:0] care;
    logic [LEN_W-1:0]       len_m1;
  } scan_cfg_t;

  typedef struct packed {
    byte_vec_t              window;
    logic                   enough;
    logic [OUT_OFF_W-1:0]   start;
    logic                   last;
  } scan_item_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_OFF_W-1:0] offset;
  } scan_result_t;

endpackage

// ===== rtl/wbps_front.sv =====
`timescale 1ns / 1ps
// front end: byte window, image byte counter, start offset and eligibility
// depends on wbps_pkg
module wbps_front import wbps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  scan_cfg_t   cfg_i,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output scan_item_t  item_o
);

  byte_vec_t              window_r, window_nxt;
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt;
  logic                   saturated;
  logic [OFFSET_BITS-1:0] start_full;

  always_comb begin
    window_nxt = {window_r[PATTERN_MAX-2:0], data_byte_i};
    saturated  = (seen_r == OFFSET_TOP);
    start_full = saturated ? OFFSET_TOP
               : seen_r - OFFSET_BITS'(cfg_i.len_m1);
    item_o.window = window_nxt;
    item_o.enough = saturated || (seen_r >= OFFSET_BITS'(cfg_i.len_m1));
    item_o.start  = start_full[OUT_OFF_W-1:0];
    item_o.last   = last_byte_i;
    seen_nxt = saturated ? seen_r : seen_r + OFFSET_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        window_r <= '0;
        seen_r   <= '0;
      end else begin
        window_r <= window_nxt;
        seen_r   <= seen_nxt;
      end
    end
  end

endmodule

// ===== rtl/wbps_queue.sv =====
`timescale 1ns / 1ps
// short queue of classified bytes between front and back end
// depends on wbps_pkg
module wbps_queue import wbps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_i,
  input  scan_item_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output scan_item_t pop_data_o
);

  scan_item_t         mem_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign full_o     = (count_r == Q_CNT_W'(QUEUE_DEPTH));
  assign valid_o    = (count_r != '0);
  assign pop_data_o = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop_i)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      if (push_i && !pop_i)      count_r <= count_r + Q_CNT_W'(1);
      else if (pop_i && !push_i) count_r <= count_r - Q_CNT_W'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (count_r != '0))
    else $error("queue popped while empty");

endmodule

// ===== rtl/wbps_back.sv =====
`timescale 1ns / 1ps
// back end: masked pattern compare, first-match tracking, result buffer
// depends on wbps_pkg
module wbps_back import wbps_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  scan_cfg_t    cfg_i,
  input  logic         item_valid_i,
  input  scan_item_t   item_i,
  output logic         item_pop_o,
  input  logic         res_pop_i,
  output logic         res_valid_o,
  output scan_result_t res_o
);

  logic                   done_r, done_nxt;
  scan_result_t           buf_r [2];
  logic [1:0]             cnt_r;
  logic                   space;
  logic [PATTERN_MAX-1:0] pos_ok;
  logic                   hit;
  logic                   res_push;
  scan_result_t           res_new;
  logic                   do_pop;
  logic [LEN_W-1:0]       idx [PATTERN_MAX];

  assign do_pop     = res_pop_i && (cnt_r != 2'd0);
  assign space      = (cnt_r != 2'd2) || do_pop;
  assign item_pop_o = item_valid_i && space;

  // pattern byte j lines up with window entry len-1-j
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      idx[j]    = cfg_i.len_m1 - LEN_W'(j);
      pos_ok[j] = (LEN_W'(j) > cfg_i.len_m1) || !cfg_i.care[j]
               || (item_i.window[idx[j]] == cfg_i.pattern[j]);
    end
    hit = item_i.enough && (&pos_ok);
  end

  always_comb begin
    res_push = 1'b0;
    res_new  = '0;
    done_nxt = done_r;
    if (item_pop_o) begin
      if (!done_r && hit) begin
        res_push       = 1'b1;
        res_new.found  = 1'b1;
        res_new.offset = item_i.start;
        done_nxt       = 1'b1;
      end else if (!done_r && item_i.last) begin
        res_push = 1'b1;
      end
      if (item_i.last) done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= done_nxt;
      cnt_r  <= cnt_r + {1'b0, res_push} - {1'b0, do_pop};
    end
  end

  // two-entry result buffer, head in entry 0
  always_ff @(posedge clk) begin
    if (do_pop) begin
      buf_r[0] <= buf_r[1];
      if (res_push) begin
        if (cnt_r == 2'd1) buf_r[0] <= res_new;
        else               buf_r[1] <= res_new;
      end
    end else if (res_push) begin
      if (cnt_r == 2'd0) buf_r[0] <= res_new;
      else               buf_r[1] <= res_new;
    end
  end

  assign res_valid_o = (cnt_r != 2'd0);
  assign res_o       = buf_r[0];

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer overflow");

  a_found_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_new.found && !item_i.last) |=> done_r)
    else $error("match reported but image not marked done");

  a_one_per_image: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && item_pop_o) |-> !res_push)
    else $error("second result within one image");

endmodule

// ===== rtl/wildcard_byte_pattern_scanner_core.sv =====
`timescale 1ns / 1ps
// top level of the wildcard byte pattern scanner: config registers and wiring
// depends on wbps_pkg, wbps_front, wbps_queue, wbps_back
//
// Scans an image byte stream for the first occurrence of a pattern of up to
// 16 bytes, where pattern bytes whose care_mask bit is clear match anything.
// Bytes are pushed one per cycle (a request is accepted when in_push is high
// and in_full low); each image gives exactly one result: found=1 with the
// start offset of its first match, or found=0 on the byte marked last_byte.
// Bytes after a match are consumed without a result. A sustained rate of one
// byte per clock is held while results are popped: the front end updates the
// window and byte counter in the accept cycle, the back end does all 16
// masked compares combinationally. The accepting edge writes the byte into
// the 4-entry queue; its compare then writes the result buffer, which drives
// the out_ ports. Results wait in this 2-entry buffer; when the consumer
// stalls, the queue absorbs four more bytes before in_full rises. The offset
// counter saturates at 2^32-1.
// Registers are written over the APB port at byte address 8*index:
// pattern low bytes, pattern high bytes, care mask, pattern length (0 acts as
// 1, above 16 acts as 16). Write them only while the block is idle.
module wildcard_byte_pattern_scanner_core import wbps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input byte stream
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  // result stream
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_found,
  output logic [OUT_OFF_W-1:0] out_match_offset,
  // configuration port
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [63:0]          cfg_pwdata,
  output logic [63:0]          cfg_prdata,
  output logic                 cfg_pready
);

  logic [63:0]            pat_lo_r, pat_hi_r;
  logic [15:0]            care_r;
  logic [4:0]             len_r;
  logic [1:0]             reg_idx;
  logic                   cfg_wr;
  scan_cfg_t              cfg;

  logic                   in_accept;
  scan_item_t             front_item;
  logic                   q_valid;
  scan_item_t             q_item;
  logic                   q_pop;
  logic                   res_valid;
  scan_result_t           res;

  // register access, byte address 8*index
  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= '1;
      len_r    <= 5'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PAT_LO:  pat_lo_r <= cfg_pwdata;
        REG_PAT_HI:  pat_hi_r <= cfg_pwdata;
        REG_CARE:    care_r   <= cfg_pwdata[15:0];
        REG_PAT_LEN: len_r    <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAT_LO:  cfg_prdata = pat_lo_r;
      REG_PAT_HI:  cfg_prdata = pat_hi_r;
      REG_CARE:    cfg_prdata = {48'd0, care_r};
      REG_PAT_LEN: cfg_prdata = {59'd0, len_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // effective length kept as length-1, clamped into 1..16
  always_comb begin
    cfg.pattern = {pat_hi_r, pat_lo_r};
    cfg.care    = care_r;
    if (len_r == 5'd0)                      cfg.len_m1 = '0;
    else if (len_r > 5'(PATTERN_MAX))       cfg.len_m1 = LEN_W'(PATTERN_MAX - 1);
    else                                    cfg.len_m1 = LEN_W'(len_r - 5'd1);
  end

  assign in_accept = in_push && !in_full;

  wbps_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg),
    .accept_i    (in_accept),
    .data_byte_i (in_data_byte),
    .last_byte_i (in_last_byte),
    .item_o      (front_item)
  );

  wbps_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (in_accept),
    .push_data_i (front_item),
    .full_o      (in_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_item)
  );

  wbps_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .res_pop_i    (out_pop),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign out_empty        = !res_valid;
  assign out_found        = res.found;
  assign out_match_offset = res.offset;

endmodule

// ===== tb/scan_result_checker.sv =====
`timescale 1ns / 1ps
// result checker of the wildcard byte pattern scanner: watches the byte,
// result and register channels, predicts each result and compares
// depends on wbps_pkg
module scan_result_checker import wbps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  logic                 out_found,
  input  logic [OUT_OFF_W-1:0] out_match_offset,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [63:0]          cfg_pwdata,
  input  logic                 cfg_pready,
  output int                   fail_count,
  output int                   outstanding
);

  // register copy
  logic [63:0]            pat_lo;
  logic [63:0]            pat_hi;
  logic [PATTERN_MAX-1:0] care;
  logic [4:0]             pat_len;

  // scan state; entry 0 of the window is the newest byte
  logic [7:0]             window [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] seen;
  logic                   image_matched;

  scan_result_t expected_results [$];
  int           fails = 0;

  function automatic void clear_image();
    int i;
    for (i = 0; i < PATTERN_MAX; i++) window[i] = 8'h00;
    seen = '0;
    image_matched = 1'b0;
  endfunction

  task automatic scan_next_byte(input logic [7:0] b, input logic last);
    logic [8*PATTERN_MAX-1:0] pat;
    scan_result_t             res;
    logic                     hit;
    int                       len;
    int                       i;
    int                       j;
    pat = {pat_hi, pat_lo};
    len = (pat_len == 5'd0) ? 1 :
          (pat_len > 5'(PATTERN_MAX)) ? PATTERN_MAX : int'(pat_len);
    for (i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = b;
    if (!image_matched) begin
      if (seen == OFFSET_TOP || seen + 1 >= len) begin
        hit = 1'b1;
        // pattern byte j sits len-1-j places behind the newest byte
        for (j = 0; j < len; j++)
          if (care[j] && window[len-1-j] != pat[8*j +: 8]) hit = 1'b0;
        if (hit) begin
          res.found  = 1'b1;
          res.offset = (seen == OFFSET_TOP) ? OUT_OFF_W'(OFFSET_TOP)
                                            : OUT_OFF_W'(seen - (len - 1));
          expected_results = {expected_results, res};
          image_matched = 1'b1;
        end
      end
      if (!image_matched && last) begin
        res.found  = 1'b0;
        res.offset = '0;
        expected_results = {expected_results, res};
      end
    end
    if (seen != OFFSET_TOP) seen++;
    if (last) clear_image();
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst_n) begin
      pat_lo  = '0;
      pat_hi  = '0;
      care    = '1;
      pat_len = 5'd1;
      clear_image();
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_PAT_LO:  pat_lo  = cfg_pwdata;
          REG_PAT_HI:  pat_hi  = cfg_pwdata;
          REG_CARE:    care    = cfg_pwdata[PATTERN_MAX-1:0];
          REG_PAT_LEN: pat_len = cfg_pwdata[4:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) scan_next_byte(in_data_byte, in_last_byte);
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, got found=%0b offset=%0d",
                   $time, out_found, out_match_offset);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found) begin
            $display("%0t: found mismatch, expected %0b got %0b",
                     $time, want.found, out_found);
            fails++;
          end
          if (out_match_offset !== want.offset) begin
            $display("%0t: match_offset mismatch, expected %0d got %0d",
                     $time, want.offset, out_match_offset);
            fails++;
          end
        end
      end
    end
    fail_count  <= fails;
    outstanding <= expected_results.size();
  end

endmodule

// ===== tb/wildcard_byte_pattern_scanner_core_test.sv =====
`timescale 1ns / 1ps
// testbench top of the wildcard byte pattern scanner: clock, reset, stimulus
// and verdict; depends on wbps_pkg, scan_result_checker and the scanner RTL
module wildcard_byte_pattern_scanner_core_test import wbps_pkg::*; ();

  localparam int PHASES       = 12;
  localparam int RANDOM_BYTES = 420;
  // run limit, far above the worst case with full idling
  localparam int CYCLE_LIMIT  = 400000;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_push      = 1'b0;
  logic                 in_full;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 in_last_byte = 1'b0;
  logic                 out_empty;
  logic                 out_pop      = 1'b0;
  logic                 out_found;
  logic [OUT_OFF_W-1:0] out_match_offset;
  logic                 cfg_psel     = 1'b0;
  logic                 cfg_penable  = 1'b0;
  logic                 cfg_pwrite   = 1'b0;
  logic [4:0]           cfg_paddr    = '0;
  logic [63:0]          cfg_pwdata   = '0;
  logic [63:0]          cfg_prdata;
  logic                 cfg_pready;

  int mismatches;
  int expected_left;
  int cycle_count = 0;

  // idling control: idle_odds 0 means no gaps, otherwise about one gap in
  // idle_odds+1 requests; calm switches idling off for the closing phases
  int idle_odds = 0;
  bit calm      = 1'b0;

  // stimulus copy of the current pattern, used to build matching images
  logic [63:0] cur_lo   = '0;
  logic [63:0] cur_hi   = '0;
  logic [15:0] cur_care = 16'hFFFF;
  logic [4:0]  cur_len  = 5'd1;

  always #2 clk = ~clk;

  wildcard_byte_pattern_scanner_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  scan_result_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_pready       (cfg_pready),
    .fail_count       (mismatches),
    .outstanding      (expected_left)
  );

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("wildcard_byte_pattern_scanner_core_test NOT OK");
      $finish;
    end
  end

  // result side: pop held high, with random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // effective pattern length, same clamping as the block applies
  function automatic int scan_len();
    if (cur_len == 5'd0) return 1;
    if (cur_len > 5'd16) return 16;
    return int'(cur_len);
  endfunction

  function automatic logic [7:0] pat_byte(input int j);
    logic [127:0] pat;
    pat = {cur_hi, cur_lo};
    return pat[8*j +: 8];
  endfunction

  // half the noise is drawn from the pattern itself so near misses are common
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) == 1) return pat_byte($urandom_range(0, scan_len() - 1));
    return 8'($urandom);
  endfunction

  // one register write: setup phase, then access phase until pready
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_scan_config(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [15:0] care, input logic [4:0] len);
    write_reg(REG_PAT_LO, lo);
    write_reg(REG_PAT_HI, hi);
    write_reg(REG_CARE, {48'h0, care});
    write_reg(REG_PAT_LEN, {59'h0, len});
    cur_lo   = lo;
    cur_hi   = hi;
    cur_care = care;
    cur_len  = len;
  endtask

  // one byte request; push stays high between back-to-back requests
  task automatic push_byte(input logic [7:0] b, input logic last);
    if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_full);
  endtask

  task automatic push_image(input logic [7:0] img [$]);
    int k;
    for (k = 0; k < img.size(); k++) push_byte(img[k], k == img.size() - 1);
  endtask

  // stop pushing, wait for every expected result, then let trailing bytes
  // that cause no result clear the pipeline before any register write
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // random image: mostly noise + pattern instance (sometimes cut short) +
  // optional tail; the rest plain noise or uniform random bytes
  task automatic send_image(output int n);
    logic [7:0] img [$];
    int         len;
    int         kind;
    int         cut;
    int         k;
    len  = scan_len();
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      repeat ($urandom_range(0, 6)) img = {img, noise_byte()};
      cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : len;
      for (k = 0; k < cut; k++)
        img = {img, cur_care[k] ? pat_byte(k) : 8'($urandom)};
      // a third of the time the pattern ends right on the last byte
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 4)) img = {img, noise_byte()};
    end else if (kind < 8) begin
      repeat ($urandom_range(1, 20)) img = {img, noise_byte()};
    end else begin
      repeat ($urandom_range(1, 12)) img = {img, 8'($urandom)};
    end
    if (img.size() == 0) img = {img, noise_byte()};
    push_image(img);
    n = img.size();
  endtask

  initial begin
    logic [7:0] img [$];
    logic [4:0] len;
    logic [15:0] care;
    int         sent;
    int         n;
    int         phase;
    int         k;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset config: single pattern byte 0x00, must match
    push_image('{8'h00});                  // match on the only, last byte
    push_image('{8'hFF, 8'h00, 8'h80});    // match at 1, trailing byte silent

    // length zero acts as one
    settle();
    set_scan_config(64'hA5, 64'h0, 16'hFFFF, 5'd0);
    push_image('{8'h5A, 8'hA5});

    // oversized length acts as 16, all wildcards: match at the last start
    settle();
    set_scan_config(64'h0, 64'h0, 16'h0000, 5'd31);
    img.delete();
    for (k = 0; k < 16; k++) img = {img, k[0] ? 8'hFF : 8'h00};
    push_image(img);

    // middle wildcard; an image shorter than the pattern cannot match
    settle();
    set_scan_config(64'h332211, 64'h0, 16'h0005, 5'd3);
    push_image('{8'h11});
    push_image('{8'h11, 8'h99, 8'h33});

    // random phases, each with its own register setting and idle rate
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: set_scan_config('0, '0, 16'hFFFF, 5'd16);
        1: set_scan_config('1, '1, 16'h0000, 5'd31);
        2: set_scan_config({$urandom, $urandom}, '1, 16'hFFFF, 5'd0);
        default: begin
          case ($urandom_range(0, 3))
            0:       care = 16'hFFFF;
            1:       care = 16'h0000;
            default: care = 16'($urandom);
          endcase
          case ($urandom_range(0, 9))
            0:       len = 5'd0;
            1:       len = 5'($urandom_range(17, 31));
            2:       len = 5'd16;
            default: len = 5'($urandom_range(1, 8));
          endcase
          set_scan_config({$urandom, $urandom}, {$urandom, $urandom}, care, len);
        end
      endcase
      idle_odds = (phase % 4 == 3) ? 0 : $urandom_range(3, 10);
      calm      = (phase >= PHASES - 2);
      sent = 0;
      while (sent < RANDOM_BYTES / PHASES) begin
        send_image(n);
        sent += n;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("wildcard_byte_pattern_scanner_core_test OK");
    end else begin
      $display("wildcard_byte_pattern_scanner_core_test NOT OK");
    end
    $finish;
  end

endmodule
